// ----- src/hex_lattice_match_triangulator_macros.svh -----
// ----------------------------------------------------------------------------
// hex_lattice_match_triangulator_macros.svh
// Assertion macros used by the verification module of the triangulator.
// ----------------------------------------------------------------------------
`ifndef HEX_LATTICE_MATCH_TRIANGULATOR_MACROS_SVH
`define HEX_LATTICE_MATCH_TRIANGULATOR_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define HLMT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("hlmt assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define HLMT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hlmt assertion failed");

`endif

// ----- src/hlmt_pkg.sv -----
// ----------------------------------------------------------------------------
// hlmt_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package hlmt_pkg;

   localparam int MAX_POSITIONS_DEF = 4096;
   localparam int MAX_MARKERS_DEF   = 4096;
   localparam int MAX_SIDE_DEF      = 64;

   localparam int FIELD_W    = 12;
   localparam int CFG_W      = 7;
   localparam int ROW_OUT_W  = 6;
   localparam int STATUS_W   = 3;
   localparam int REQ_W      = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CFG_W-1:0] SIDE_RESET = 7'd5;

   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;

   typedef enum logic [REQ_W-1:0] {
      REQ_CLEAR = 2'd0,
      REQ_ADD   = 2'd1,
      REQ_SCAN  = 2'd2
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_DUPLICATE = 3'd1,
      STAT_RANGE     = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_PAST_END  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_RST_SWEEP,
      ST_IDLE,
      ST_CLR_SWEEP,
      ST_CLR_EMIT,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_SCAN_START,
      ST_SCAN_END,
      ST_COL_A,
      ST_COL_B,
      ST_COL_C,
      ST_COL_D,
      ST_COL_E,
      ST_SCAN_FIN
   } state_type;

   typedef enum logic [2:0] {
      EM_CLEAR,
      EM_ADD,
      EM_PAST_END,
      EM_PEND,
      EM_FINAL
   } emit_type;

   typedef enum logic [1:0] {
      AS_A,
      AS_B,
      AS_C
   } addr_sel_type;

   typedef struct packed {
      logic         sweep_en;
      logic         clear_state;
      logic         add_load;
      logic         add_commit;
      logic         scan_start;
      logic         addr_load;
      addr_sel_type addr_sel;
      logic         latch_m1;
      logic         latch_m2;
      logic         col_step;
      logic         pend_store;
      logic         emit;
      emit_type     emit_kind;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic out_free;
      logic past_end;
      logic hit;
      logic pend_valid;
      logic last_col;
   } stat_type;

endpackage

`default_nettype wire

// ----- src/hlmt_csr.sv -----
// ----------------------------------------------------------------------------
// hlmt_csr
// Lattice size registers behind the APB-style configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module hlmt_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [hlmt_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [hlmt_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [hlmt_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output logic [hlmt_pkg::CFG_W-1:0]        rows_cfg,
   output logic [hlmt_pkg::CFG_W-1:0]        cols_cfg
);

   logic [hlmt_pkg::CFG_W-1:0] rows_ff;
   logic [hlmt_pkg::CFG_W-1:0] rows_in;
   logic [hlmt_pkg::CFG_W-1:0] cols_ff;
   logic [hlmt_pkg::CFG_W-1:0] cols_in;
   logic                       wr_en;

   assign wr_en = psel && penable && pwrite;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (wr_en && paddr[2] == hlmt_pkg::REG_ROWS) begin
         rows_in = pwdata[hlmt_pkg::CFG_W-1:0];
      end
      if (wr_en && paddr[2] == hlmt_pkg::REG_COLS) begin
         cols_in = pwdata[hlmt_pkg::CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= hlmt_pkg::SIDE_RESET;
         cols_ff <= hlmt_pkg::SIDE_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   assign prdata   = (paddr[2] == hlmt_pkg::REG_COLS) ?
                     hlmt_pkg::CSR_DATA_W'(cols_ff) : hlmt_pkg::CSR_DATA_W'(rows_ff);
   assign pready   = 1'b1;
   assign rows_cfg = rows_ff;
   assign cols_cfg = cols_ff;

endmodule

`default_nettype wire

// ----- src/hlmt_ctrl.sv -----
// ----------------------------------------------------------------------------
// hlmt_ctrl
// Sequencer for table sweeps, match loads and band scans.
// ----------------------------------------------------------------------------
`default_nettype none

module hlmt_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [hlmt_pkg::REQ_W-1:0]    req_type,
   input  hlmt_pkg::stat_type            stat,
   output hlmt_pkg::cmd_type             cmd
);

   hlmt_pkg::state_type state_ff;
   hlmt_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hlmt_pkg::ST_RST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         hlmt_pkg::ST_RST_SWEEP: begin
            cmd.sweep_en = 1'b1;
            if (stat.sweep_last) begin
               state_in = hlmt_pkg::ST_IDLE;
            end
         end
         hlmt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_type)
                  hlmt_pkg::REQ_CLEAR: begin
                     cmd.clear_state = 1'b1;
                     state_in        = hlmt_pkg::ST_CLR_SWEEP;
                  end
                  hlmt_pkg::REQ_ADD: begin
                     cmd.add_load = 1'b1;
                     state_in     = hlmt_pkg::ST_ADD_RD;
                  end
                  hlmt_pkg::REQ_SCAN: begin
                     state_in = hlmt_pkg::ST_SCAN_START;
                  end
                  default: begin
                     state_in = hlmt_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         hlmt_pkg::ST_CLR_SWEEP: begin
            cmd.sweep_en = 1'b1;
            if (stat.sweep_last) begin
               state_in = hlmt_pkg::ST_CLR_EMIT;
            end
         end
         hlmt_pkg::ST_CLR_EMIT: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = hlmt_pkg::EM_CLEAR;
               state_in      = hlmt_pkg::ST_IDLE;
            end
         end
         hlmt_pkg::ST_ADD_RD: begin
            state_in = hlmt_pkg::ST_ADD_WR;
         end
         hlmt_pkg::ST_ADD_WR: begin
            if (stat.out_free) begin
               cmd.add_commit = 1'b1;
               cmd.emit       = 1'b1;
               cmd.emit_kind  = hlmt_pkg::EM_ADD;
               state_in       = hlmt_pkg::ST_IDLE;
            end
         end
         hlmt_pkg::ST_SCAN_START: begin
            cmd.scan_start = 1'b1;
            state_in = stat.past_end ? hlmt_pkg::ST_SCAN_END : hlmt_pkg::ST_COL_A;
         end
         hlmt_pkg::ST_SCAN_END: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = hlmt_pkg::EM_PAST_END;
               state_in      = hlmt_pkg::ST_IDLE;
            end
         end
         hlmt_pkg::ST_COL_A: begin
            cmd.addr_load = 1'b1;
            cmd.addr_sel  = hlmt_pkg::AS_A;
            state_in      = hlmt_pkg::ST_COL_B;
         end
         hlmt_pkg::ST_COL_B: begin
            cmd.addr_load = 1'b1;
            cmd.addr_sel  = hlmt_pkg::AS_B;
            state_in      = hlmt_pkg::ST_COL_C;
         end
         hlmt_pkg::ST_COL_C: begin
            cmd.addr_load = 1'b1;
            cmd.addr_sel  = hlmt_pkg::AS_C;
            cmd.latch_m1  = 1'b1;
            state_in      = hlmt_pkg::ST_COL_D;
         end
         hlmt_pkg::ST_COL_D: begin
            cmd.latch_m2 = 1'b1;
            state_in     = hlmt_pkg::ST_COL_E;
         end
         hlmt_pkg::ST_COL_E: begin
            if (!(stat.hit && stat.pend_valid && !stat.out_free)) begin
               if (stat.hit) begin
                  cmd.pend_store = 1'b1;
                  if (stat.pend_valid) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_kind = hlmt_pkg::EM_PEND;
                  end
               end
               if (stat.last_col) begin
                  state_in = hlmt_pkg::ST_SCAN_FIN;
               end else begin
                  cmd.col_step = 1'b1;
                  state_in     = hlmt_pkg::ST_COL_A;
               end
            end
         end
         hlmt_pkg::ST_SCAN_FIN: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = hlmt_pkg::EM_FINAL;
               state_in      = hlmt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hlmt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- src/hlmt_datapath.sv -----
// ----------------------------------------------------------------------------
// hlmt_datapath
// Position table, marker counter, scan cursor, column walk and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hlmt_datapath #(
   parameter int MAX_POSITIONS = hlmt_pkg::MAX_POSITIONS_DEF,
   parameter int MAX_MARKERS   = hlmt_pkg::MAX_MARKERS_DEF,
   parameter int MAX_SIDE      = hlmt_pkg::MAX_SIDE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  hlmt_pkg::cmd_type                 cmd,
   output hlmt_pkg::stat_type                stat,
   input  logic [hlmt_pkg::FIELD_W-1:0]      req_pattern_index,
   input  logic [hlmt_pkg::CFG_W-1:0]        rows_cfg,
   input  logic [hlmt_pkg::CFG_W-1:0]        cols_cfg,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic                              rsp_tri_valid,
   output logic [hlmt_pkg::FIELD_W-1:0]      rsp_corner_a,
   output logic [hlmt_pkg::FIELD_W-1:0]      rsp_corner_b,
   output logic [hlmt_pkg::FIELD_W-1:0]      rsp_corner_c,
   output logic                              rsp_pointing_down,
   output logic [hlmt_pkg::ROW_OUT_W-1:0]    rsp_band_row,
   output logic                              rsp_last_in_run,
   output logic                              rsp_mesh_done,
   output logic [hlmt_pkg::STATUS_W-1:0]     rsp_status
);

   localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
   localparam int CALC_W  = 2 * SIDE_W + 1;
   localparam int POS_W   = $clog2(MAX_POSITIONS);
   localparam int MK_W    = $clog2(MAX_MARKERS + 1);
   localparam int FW      = hlmt_pkg::FIELD_W;
   localparam int ENTRY_W = FW + 1;

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [hlmt_pkg::CFG_W-1:0] v);
      if (v < 7'd2) begin
         return SIDE_W'(2);
      end
      if (32'(v) > MAX_SIDE) begin
         return SIDE_W'(MAX_SIDE);
      end
      return SIDE_W'(v);
   endfunction

   // table: {valid, marker}
   logic [ENTRY_W-1:0] mem [MAX_POSITIONS];
   logic [ENTRY_W-1:0] rdata_ff;
   logic               mem_we;
   logic [POS_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   logic [SIDE_W-1:0]  rows_ff, rows_in, cols_ff, cols_in;
   logic [CALC_W-1:0]  area_ff, area_in;

   logic               fin_ff, fin_in, down_ff, down_in;
   logic [SIDE_W-1:0]  row_ff, row_in;
   logic [MK_W-1:0]    marker_ff, marker_in;
   logic [POS_W-1:0]   sweep_ff, sweep_in;
   logic [FW-1:0]      pos_ff, pos_in;
   logic [POS_W-1:0]   addr_ff, addr_in;

   logic [SIDE_W-1:0]  band_row_ff, band_row_in;
   logic               band_down_ff, band_down_in;
   logic               band_done_ff, band_done_in;
   logic [CALC_W-1:0]  base_ff, base_in;
   logic [SIDE_W-1:0]  col_ff, col_in;
   logic [FW-1:0]      m1_ff, m1_in, m2_ff, m2_in;
   logic               v1_ff, v1_in, v2_ff, v2_in;
   logic               pend_ff, pend_in;
   logic [FW-1:0]      pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in;

   logic               o_valid_ff, o_valid_in;
   logic               o_tri_ff, o_tri_in;
   logic [FW-1:0]      o_a_ff, o_a_in, o_b_ff, o_b_in, o_c_ff, o_c_in;
   logic               o_down_ff, o_down_in;
   logic [SIDE_W-1:0]  o_row_ff, o_row_in;
   logic               o_last_ff, o_last_in;
   logic               o_done_ff, o_done_in;
   hlmt_pkg::status_type o_stat_ff, o_stat_in;

   logic               adj_fin, adj_down;
   logic [SIDE_W-1:0]  adj_row;
   logic               nxt_fin, nxt_down;
   logic [SIDE_W-1:0]  nxt_row;
   logic [CALC_W-1:0]  a_addr, b_addr, c_addr;
   logic               ok_a, ok_b, ok_c;
   logic               hit;
   logic [FW-1:0]      m3;
   logic [FW-1:0]      tri_b, tri_c;
   logic               sweep_last;
   logic               out_free;
   hlmt_pkg::status_type add_status;

   assign rows_in = clamp_side(rows_cfg);
   assign cols_in = clamp_side(cols_cfg);
   assign area_in = CALC_W'(rows_in) * CALC_W'(cols_in);

   // cursor: fold a stale position into the band sequence, then advance past it
   always_comb begin
      adj_fin  = fin_ff;
      adj_down = down_ff;
      adj_row  = row_ff;
      if (!adj_fin && !adj_down && adj_row > rows_ff - SIDE_W'(2)) begin
         adj_down = 1'b1;
         adj_row  = SIDE_W'(1);
      end
      if (!adj_fin && adj_down &&
          (adj_row < SIDE_W'(1) || adj_row > rows_ff - SIDE_W'(1))) begin
         adj_fin = 1'b1;
      end
      nxt_fin  = adj_fin;
      nxt_down = adj_down;
      nxt_row  = adj_row;
      if (!adj_down) begin
         if (adj_row >= rows_ff - SIDE_W'(2)) begin
            nxt_down = 1'b1;
            nxt_row  = SIDE_W'(1);
         end else begin
            nxt_row = adj_row + SIDE_W'(1);
         end
      end else begin
         if (adj_row >= rows_ff - SIDE_W'(1)) begin
            nxt_fin = 1'b1;
         end else begin
            nxt_row = adj_row + SIDE_W'(1);
         end
      end
   end

   assign a_addr = base_ff + CALC_W'(col_ff);
   assign b_addr = a_addr + CALC_W'(1);
   assign c_addr = band_down_ff ?
                   a_addr - CALC_W'(cols_ff) + CALC_W'(band_row_ff[0]) :
                   a_addr + CALC_W'(cols_ff) + CALC_W'(band_row_ff[0]);
   assign ok_a   = 32'(a_addr) < MAX_POSITIONS;
   assign ok_b   = 32'(b_addr) < MAX_POSITIONS;
   assign ok_c   = 32'(c_addr) < MAX_POSITIONS;

   assign m3    = rdata_ff[FW-1:0];
   assign hit   = v1_ff && v2_ff && rdata_ff[FW] && ok_c;
   assign tri_b = band_down_ff ? m3 : m2_ff;
   assign tri_c = band_down_ff ? m2_ff : m3;

   assign sweep_last = (sweep_ff == POS_W'(MAX_POSITIONS - 1));
   assign out_free   = !o_valid_ff || rsp_ready;

   always_comb begin
      if (marker_ff == MK_W'(MAX_MARKERS)) begin
         add_status = hlmt_pkg::STAT_FULL;
      end else if (32'(pos_ff) >= 32'(area_ff) || 32'(pos_ff) >= MAX_POSITIONS) begin
         add_status = hlmt_pkg::STAT_RANGE;
      end else if (rdata_ff[FW]) begin
         add_status = hlmt_pkg::STAT_DUPLICATE;
      end else begin
         add_status = hlmt_pkg::STAT_OK;
      end
   end

   assign mem_we    = cmd.sweep_en || (cmd.add_commit && add_status == hlmt_pkg::STAT_OK);
   assign mem_waddr = cmd.sweep_en ? sweep_ff : addr_ff;
   assign mem_wdata = cmd.sweep_en ? '0 : {1'b1, FW'(marker_ff)};

   always_comb begin
      fin_in       = fin_ff;
      down_in      = down_ff;
      row_in       = row_ff;
      marker_in    = marker_ff;
      sweep_in     = sweep_ff;
      pos_in       = pos_ff;
      addr_in      = addr_ff;
      band_row_in  = band_row_ff;
      band_down_in = band_down_ff;
      band_done_in = band_done_ff;
      base_in      = base_ff;
      col_in       = col_ff;
      m1_in        = m1_ff;
      m2_in        = m2_ff;
      v1_in        = v1_ff;
      v2_in        = v2_ff;
      pend_in      = pend_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      pc_in        = pc_ff;

      if (cmd.sweep_en) begin
         sweep_in = sweep_last ? '0 : sweep_ff + POS_W'(1);
      end
      if (cmd.clear_state) begin
         fin_in    = 1'b0;
         down_in   = 1'b0;
         row_in    = '0;
         marker_in = '0;
         sweep_in  = '0;
      end
      if (cmd.add_load) begin
         pos_in  = req_pattern_index;
         addr_in = POS_W'(req_pattern_index);
      end
      if (cmd.add_commit && add_status != hlmt_pkg::STAT_FULL) begin
         marker_in = marker_ff + MK_W'(1);
      end
      if (cmd.scan_start) begin
         if (adj_fin) begin
            fin_in  = 1'b1;
            down_in = adj_down;
            row_in  = adj_row;
         end else begin
            fin_in       = nxt_fin;
            down_in      = nxt_down;
            row_in       = nxt_row;
            band_row_in  = adj_row;
            band_down_in = adj_down;
            band_done_in = nxt_fin;
            base_in      = CALC_W'(adj_row) * CALC_W'(cols_ff);
            col_in       = '0;
            pend_in      = 1'b0;
         end
      end
      if (cmd.addr_load) begin
         case (cmd.addr_sel)
            hlmt_pkg::AS_A: addr_in = POS_W'(a_addr);
            hlmt_pkg::AS_B: addr_in = POS_W'(b_addr);
            hlmt_pkg::AS_C: addr_in = POS_W'(c_addr);
            default:        addr_in = addr_ff;
         endcase
      end
      if (cmd.latch_m1) begin
         m1_in = rdata_ff[FW-1:0];
         v1_in = rdata_ff[FW] && ok_a;
      end
      if (cmd.latch_m2) begin
         m2_in = rdata_ff[FW-1:0];
         v2_in = rdata_ff[FW] && ok_b;
      end
      if (cmd.pend_store) begin
         pend_in = 1'b1;
         pa_in   = m1_ff;
         pb_in   = tri_b;
         pc_in   = tri_c;
      end
      if (cmd.col_step) begin
         col_in = col_ff + SIDE_W'(1);
      end
   end

   always_comb begin
      o_valid_in = o_valid_ff && !rsp_ready;
      o_tri_in   = o_tri_ff;
      o_a_in     = o_a_ff;
      o_b_in     = o_b_ff;
      o_c_in     = o_c_ff;
      o_down_in  = o_down_ff;
      o_row_in   = o_row_ff;
      o_last_in  = o_last_ff;
      o_done_in  = o_done_ff;
      o_stat_in  = o_stat_ff;
      if (cmd.emit) begin
         o_valid_in = 1'b1;
         o_tri_in   = 1'b0;
         o_a_in     = '0;
         o_b_in     = '0;
         o_c_in     = '0;
         o_down_in  = 1'b0;
         o_row_in   = '0;
         o_last_in  = 1'b1;
         o_done_in  = 1'b0;
         o_stat_in  = hlmt_pkg::STAT_OK;
         case (cmd.emit_kind)
            hlmt_pkg::EM_CLEAR: begin
               o_done_in = 1'b0;
            end
            hlmt_pkg::EM_ADD: begin
               o_done_in = fin_ff;
               o_stat_in = add_status;
            end
            hlmt_pkg::EM_PAST_END: begin
               o_done_in = 1'b1;
               o_stat_in = hlmt_pkg::STAT_PAST_END;
            end
            hlmt_pkg::EM_PEND: begin
               o_tri_in  = 1'b1;
               o_a_in    = pa_ff;
               o_b_in    = pb_ff;
               o_c_in    = pc_ff;
               o_down_in = band_down_ff;
               o_row_in  = band_row_ff;
               o_last_in = 1'b0;
               o_done_in = band_done_ff;
            end
            hlmt_pkg::EM_FINAL: begin
               o_tri_in  = pend_ff;
               o_a_in    = pend_ff ? pa_ff : '0;
               o_b_in    = pend_ff ? pb_ff : '0;
               o_c_in    = pend_ff ? pc_ff : '0;
               o_down_in = band_down_ff;
               o_row_in  = band_row_ff;
               o_done_in = band_done_ff;
            end
            default: begin
               o_valid_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff     <= 1'b0;
         down_ff    <= 1'b0;
         row_ff     <= '0;
         marker_ff  <= '0;
         sweep_ff   <= '0;
         pend_ff    <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         fin_ff     <= fin_in;
         down_ff    <= down_in;
         row_ff     <= row_in;
         marker_ff  <= marker_in;
         sweep_ff   <= sweep_in;
         pend_ff    <= pend_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rows_ff      <= rows_in;
      cols_ff      <= cols_in;
      area_ff      <= area_in;
      pos_ff       <= pos_in;
      addr_ff      <= addr_in;
      band_row_ff  <= band_row_in;
      band_down_ff <= band_down_in;
      band_done_ff <= band_done_in;
      base_ff      <= base_in;
      col_ff       <= col_in;
      m1_ff        <= m1_in;
      m2_ff        <= m2_in;
      v1_ff        <= v1_in;
      v2_ff        <= v2_in;
      pa_ff        <= pa_in;
      pb_ff        <= pb_in;
      pc_ff        <= pc_in;
      o_tri_ff     <= o_tri_in;
      o_a_ff       <= o_a_in;
      o_b_ff       <= o_b_in;
      o_c_ff       <= o_c_in;
      o_down_ff    <= o_down_in;
      o_row_ff     <= o_row_in;
      o_last_ff    <= o_last_in;
      o_done_ff    <= o_done_in;
      o_stat_ff    <= o_stat_in;
   end

   assign stat.sweep_last = sweep_last;
   assign stat.out_free   = out_free;
   assign stat.past_end   = adj_fin;
   assign stat.hit        = hit;
   assign stat.pend_valid = pend_ff;
   assign stat.last_col   = (col_ff == cols_ff - SIDE_W'(2));

   assign rsp_valid         = o_valid_ff;
   assign rsp_tri_valid     = o_tri_ff;
   assign rsp_corner_a      = o_a_ff;
   assign rsp_corner_b      = o_b_ff;
   assign rsp_corner_c      = o_c_ff;
   assign rsp_pointing_down = o_down_ff;
   assign rsp_band_row      = hlmt_pkg::ROW_OUT_W'(o_row_ff);
   assign rsp_last_in_run   = o_last_ff;
   assign rsp_mesh_done     = o_done_ff;
   assign rsp_status        = o_stat_ff;

endmodule

`default_nettype wire

// ----- src/hex_lattice_match_triangulator.sv -----
// One transaction in flight at a time; a band scan can also be held by output stalls.
// Throughput is set by the single read port of the position table: three reads per column.
// Reset: synchronous; after reset a clearing pass over all MAX_POSITIONS entries runs with
// req_ready low, configuration writes still taken. Clear transactions repeat the pass.
// ----------------------------------------------------------------------------
// hex_lattice_match_triangulator
// Marker-to-lattice match table with row band triangle scan.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_lattice_match_triangulator #(
   parameter int MAX_POSITIONS = hlmt_pkg::MAX_POSITIONS_DEF,
   parameter int MAX_MARKERS   = hlmt_pkg::MAX_MARKERS_DEF,
   parameter int MAX_SIDE      = hlmt_pkg::MAX_SIDE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [hlmt_pkg::REQ_W-1:0]        req_type,
   input  logic [hlmt_pkg::FIELD_W-1:0]      req_pattern_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_tri_valid,
   output logic [hlmt_pkg::FIELD_W-1:0]      rsp_corner_a,
   output logic [hlmt_pkg::FIELD_W-1:0]      rsp_corner_b,
   output logic [hlmt_pkg::FIELD_W-1:0]      rsp_corner_c,
   output logic                              rsp_pointing_down,
   output logic [hlmt_pkg::ROW_OUT_W-1:0]    rsp_band_row,
   output logic                              rsp_last_in_run,
   output logic                              rsp_mesh_done,
   output logic [hlmt_pkg::STATUS_W-1:0]     rsp_status,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [hlmt_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [hlmt_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [hlmt_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   hlmt_pkg::cmd_type          cmd;
   hlmt_pkg::stat_type         stat;
   logic [hlmt_pkg::CFG_W-1:0] rows_cfg;
   logic [hlmt_pkg::CFG_W-1:0] cols_cfg;

   hlmt_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .rows_cfg (rows_cfg),
      .cols_cfg (cols_cfg)
   );

   hlmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .stat      (stat),
      .cmd       (cmd)
   );

   hlmt_datapath #(
      .MAX_POSITIONS (MAX_POSITIONS),
      .MAX_MARKERS   (MAX_MARKERS),
      .MAX_SIDE      (MAX_SIDE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_pattern_index (req_pattern_index),
      .rows_cfg          (rows_cfg),
      .cols_cfg          (cols_cfg),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_tri_valid     (rsp_tri_valid),
      .rsp_corner_a      (rsp_corner_a),
      .rsp_corner_b      (rsp_corner_b),
      .rsp_corner_c      (rsp_corner_c),
      .rsp_pointing_down (rsp_pointing_down),
      .rsp_band_row      (rsp_band_row),
      .rsp_last_in_run   (rsp_last_in_run),
      .rsp_mesh_done     (rsp_mesh_done),
      .rsp_status        (rsp_status)
   );

endmodule

`default_nettype wire

// ----- src/hlmt_assert.sv -----
// ----------------------------------------------------------------------------
// hlmt_assert
// Port-level checks on result transactions of the triangulator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hex_lattice_match_triangulator_macros.svh"

module hlmt_assert (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_tri_valid,
   input logic [hlmt_pkg::FIELD_W-1:0]      rsp_corner_a,
   input logic [hlmt_pkg::FIELD_W-1:0]      rsp_corner_b,
   input logic [hlmt_pkg::FIELD_W-1:0]      rsp_corner_c,
   input logic                              rsp_last_in_run,
   input logic                              rsp_mesh_done,
   input logic [hlmt_pkg::STATUS_W-1:0]     rsp_status
);

   `HLMT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_corner_a) && $stable(rsp_status))
   `HLMT_ASSERT_IMPL(a_tri_ok, clock, reset, rsp_valid && rsp_tri_valid, rsp_status == hlmt_pkg::STAT_OK)
   `HLMT_ASSERT_IMPL(a_empty_zero, clock, reset, rsp_valid && !rsp_tri_valid, rsp_corner_a == '0 && rsp_corner_b == '0 && rsp_corner_c == '0)
   `HLMT_ASSERT_IMPL(a_past_end, clock, reset, rsp_valid && rsp_status == hlmt_pkg::STAT_PAST_END, rsp_mesh_done && rsp_last_in_run)
   `HLMT_ASSERT_IMPL(a_err_single, clock, reset, rsp_valid && rsp_status != hlmt_pkg::STAT_OK, rsp_last_in_run && !rsp_tri_valid)

endmodule

bind hex_lattice_match_triangulator hlmt_assert u_hlmt_assert (.*);

`default_nettype wire
